// ===== rtl/akt_pkg.sv =====
// Shared constants and register codes for the anisotropic kernel block.
`default_nettype none

package akt_pkg;

  localparam int unsigned REG_W     = 32;
  localparam int unsigned TEN_W     = 32;
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_TRANSITION = 3'd1,
    REG_DETAIL     = 3'd2,
    REG_DENOISE    = 3'd3,
    REG_STRETCH    = 3'd4,
    REG_SHRINK     = 3'd5
  } cfg_reg_e;

  localparam logic [REG_W-1:0] RST_THRESHOLD  = 32'd83886;
  localparam logic [REG_W-1:0] RST_TRANSITION = 32'd167772;
  localparam logic [REG_W-1:0] RST_DETAIL     = 32'd5033165;
  localparam logic [REG_W-1:0] RST_DENOISE    = 32'd67108864;
  localparam logic [REG_W-1:0] RST_STRETCH    = 32'd67108864;
  localparam logic [REG_W-1:0] RST_SHRINK     = 32'd33554432;

  localparam logic [24:0]      ONE24   = 25'h1000000;
  localparam logic [28:0]      ONE28   = 29'h10000000;
  localparam logic [OUT_W-1:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 48'h8000_0000_0000;
  localparam logic [57:0]      R_NUM   = 58'h100_0000_0000_0000;

endpackage

`default_nettype wire

// ===== rtl/anisotropic_kernel_from_tensor_top.sv =====
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// The depth comes from the bit-per-stage square roots and dividers (two 57-stage
// reciprocals dominate). Detail and shrink writes settle through the config divider.
// Reset: registers return to their defaults, all valid bits clear; no clearing pass.
`default_nettype none

module anisotropic_kernel_from_tensor_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [akt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [akt_pkg::REG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [akt_pkg::TEN_W-1:0]           tensor_xx_i,
  input  logic [akt_pkg::TEN_W-1:0]           tensor_yy_i,
  input  logic signed [akt_pkg::TEN_W-1:0]    tensor_xy_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [akt_pkg::OUT_W-1:0]    inverse_xx_o,
  output logic signed [akt_pkg::OUT_W-1:0]    inverse_yy_o,
  output logic signed [akt_pkg::OUT_W-1:0]    inverse_xy_o,
  output logic                                saturated_o
);

  import akt_pkg::*;

  typedef struct packed {
    logic [32:0] d;
    logic [31:0] ax;
    logic [32:0] t;
    logic        neg;
  } h_side_t;

  typedef struct packed {
    logic [33:0] num;
    logic [31:0] hh;
    logic [31:0] ax;
    logic [32:0] t;
    logic        neg;
    logic        hz;
    logic [32:0] lam;
    logic        tz;
    logic        abig;
  } p4_t;

  typedef struct packed {
    p4_t         p;
    logic [28:0] c2;
  } cs_side_t;

  typedef struct packed {
    cs_side_t    c;
    logic [27:0] csm;
  } an_side_t;

  typedef struct packed {
    logic [28:0] c2;
    logic [27:0] csm;
    logic        neg;
    logic [31:0] aniso;
  } rt_side_t;

  typedef struct packed {
    rt_side_t r;
    logic     ovf;
  } dw_side_t;

  typedef struct packed {
    logic [47:0] kr2;
    logic [28:0] c2;
    logic [27:0] csm;
    logic        neg;
  } r1_side_t;

  typedef struct packed {
    logic [56:0] r1;
    logic [28:0] c2;
    logic [27:0] csm;
    logic        neg;
  } r2_side_t;

  // configuration
  logic [31:0] thr_q, trn_q, det_q, dns_q, str_q, shk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= RST_THRESHOLD;
      trn_q <= RST_TRANSITION;
      det_q <= RST_DETAIL;
      dns_q <= RST_DENOISE;
      str_q <= RST_STRETCH;
      shk_q <= RST_SHRINK;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD:  thr_q <= cfg_data_i;
        REG_TRANSITION: trn_q <= cfg_data_i;
        REG_DETAIL:     det_q <= cfg_data_i;
        REG_DENOISE:    dns_q <= cfg_data_i;
        REG_STRETCH:    str_q <= cfg_data_i;
        REG_SHRINK:     shk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] dtr, shr;
  logic [63:0] ks_prod, base_prod;
  logic [31:0] ks_q, base_q, kq_q;
  logic        kq_ovf, kq_vld, kq_side;
  logic [31:0] kq_quo;

  assign dtr       = (trn_q == '0) ? 32'd1 : trn_q;
  assign shr       = (shk_q == '0) ? 32'd1 : shk_q;
  assign ks_prod   = det_q * str_q;
  assign base_prod = det_q * dns_q;
  assign kq_ovf    = {8'd0, det_q} >= {shr, 8'd0};

  always_ff @(posedge clk_i) begin
    ks_q   <= (ks_prod[63:56] != '0) ? '1 : ks_prod[55:24];
    base_q <= (base_prod[63:56] != '0) ? '1 : base_prod[55:24];
    if (kq_vld) begin
      kq_q <= kq_side ? '1 : kq_quo;
    end
  end

  // config-only quotient, runs every cycle
  akt_div #(.NW(56), .DW(32), .QW(32), .SW(1)) u_div_kq (
    .clk_i, .rst_ni, .en_i(1'b1), .vld_i(1'b1),
    .num_i({det_q, 24'd0}), .den_i(shr), .side_i(kq_ovf),
    .vld_o(kq_vld), .quo_o(kq_quo), .side_o(kq_side)
  );

  // pipeline
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  logic        v1_q, v2_q, v3_q;
  h_side_t     h1_q, h2_q, h3_q;
  logic [31:0] ad1_q;
  logic [63:0] ad2_q, ax2_q, v3r_q;
  logic [32:0] d_in;
  logic [31:0] ad_in, ax_in;

  assign d_in  = {1'b0, tensor_yy_i} - {1'b0, tensor_xx_i};
  assign ad_in = d_in[32] ? 32'(-d_in) : d_in[31:0];
  assign ax_in = tensor_xy_i[31] ? (~tensor_xy_i + 32'd1) : tensor_xy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_q.d   <= d_in;
      h1_q.ax  <= ax_in;
      h1_q.t   <= {1'b0, tensor_xx_i} + {1'b0, tensor_yy_i};
      h1_q.neg <= tensor_xy_i[31];
      ad1_q    <= ad_in;
      h2_q     <= h1_q;
      ad2_q    <= ad1_q * ad1_q;
      ax2_q    <= h1_q.ax * h1_q.ax;
      h3_q     <= h2_q;
      v3r_q    <= {2'b00, ad2_q[63:2]} + ax2_q;
    end
  end

  logic        vh;
  logic [31:0] hh;
  h_side_t     hs;

  akt_sqrt #(.IW(64), .SW($bits(h_side_t))) u_sqrt_h (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v3_q), .rad_i(v3r_q), .side_i(h3_q),
    .vld_o(vh), .root_o(hh), .side_o(hs)
  );

  logic [32:0] h2x;
  logic [34:0] num_raw;
  logic [33:0] num_cl;
  logic [33:0] lam_sum;
  logic        v4_q;
  p4_t         p4_q;

  assign h2x     = {hh, 1'b0};
  assign num_raw = {2'b00, h2x} - {{2{hs.d[32]}}, hs.d};
  assign num_cl  = num_raw[34] ? '0 :
                   (num_raw[33:0] > {hh, 2'b00}) ? {hh, 2'b00} : num_raw[33:0];
  assign lam_sum = {1'b0, hs.t} + {1'b0, h2x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q.num  <= num_cl;
      p4_q.hh   <= hh;
      p4_q.ax   <= hs.ax;
      p4_q.t    <= hs.t;
      p4_q.neg  <= hs.neg;
      p4_q.hz   <= hh == '0;
      p4_q.lam  <= lam_sum[33:1];
      p4_q.tz   <= hs.t == '0;
      p4_q.abig <= {8'd0, h2x} >= {hs.t, 8'd0};
    end
  end

  logic        vc2;
  logic [28:0] c2q;
  p4_t         pc2;

  akt_div #(.NW(62), .DW(34), .QW(29), .SW($bits(p4_t))) u_div_c2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v4_q),
    .num_i({p4_q.num, 28'd0}), .den_i({p4_q.hh, 2'b00}), .side_i(p4_q),
    .vld_o(vc2), .quo_o(c2q), .side_o(pc2)
  );

  cs_side_t    cs_in;
  logic        vcs;
  logic [27:0] csq;
  cs_side_t    pcs;

  assign cs_in.p  = pc2;
  assign cs_in.c2 = pc2.hz ? ONE28 : c2q;

  akt_div #(.NW(60), .DW(33), .QW(28), .SW($bits(cs_side_t))) u_div_cs (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vc2),
    .num_i({pc2.ax, 28'd0}), .den_i({pc2.hh, 1'b0}), .side_i(cs_in),
    .vld_o(vcs), .quo_o(csq), .side_o(pcs)
  );

  an_side_t    an_in;
  logic        van;
  logic [31:0] anq;
  an_side_t    pan;

  assign an_in.c   = pcs;
  assign an_in.csm = pcs.p.hz ? '0 : csq;

  akt_div #(.NW(57), .DW(33), .QW(32), .SW($bits(an_side_t))) u_div_an (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vcs),
    .num_i({pcs.p.hh, 1'b0, 24'd0}), .den_i(pcs.p.t), .side_i(an_in),
    .vld_o(van), .quo_o(anq), .side_o(pan)
  );

  logic [32:0] an_sum;
  rt_side_t    rt_in;
  logic        vrt;
  logic [26:0] root;
  rt_side_t    prt;

  assign an_sum      = {1'b0, anq} + 33'(ONE24);
  assign rt_in.c2    = pan.c.c2;
  assign rt_in.csm   = pan.csm;
  assign rt_in.neg   = pan.c.p.neg;
  assign rt_in.aniso = pan.c.p.tz   ? 32'(ONE24) :
                       pan.c.p.abig ? '1 :
                       an_sum[32]   ? '1 : an_sum[31:0];

  akt_sqrt #(.IW(54), .SW($bits(rt_side_t))) u_sqrt_r (
    .clk_i, .rst_ni, .en_i(en), .vld_i(van),
    .rad_i({1'b0, pan.c.p.lam, 20'd0}), .side_i(rt_in),
    .vld_o(vrt), .root_o(root), .side_o(prt)
  );

  dw_side_t    dw_in;
  logic        vdw;
  logic [33:0] dq;
  dw_side_t    pdw;

  assign dw_in.r   = prt;
  assign dw_in.ovf = {15'd0, root} >= {dtr, 10'd0};

  akt_div #(.NW(51), .DW(32), .QW(34), .SW($bits(dw_side_t))) u_div_dw (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vrt),
    .num_i({root, 24'd0}), .den_i(dtr), .side_i(dw_in),
    .vld_o(vdw), .quo_o(dq), .side_o(pdw)
  );

  logic [35:0] dw_raw;
  logic [24:0] dw_cl;

  assign dw_raw = {3'd0, 33'(ONE24) + {1'b0, thr_q}} - {2'b00, dq};
  assign dw_cl  = (pdw.ovf || dw_raw[35]) ? '0 :
                  (dw_raw > 36'(ONE24))   ? ONE24 : dw_raw[24:0];

  logic        v5_q, v6_q, v7_q, v8_q, v9_q;
  logic [24:0] dw5_q, dw6_q, wdw6_q;
  logic [63:0] p1_5_q, p2_5_q;
  logic [31:0] k1h6_q, k2h6_q;
  logic [56:0] m1_q, m2_q, mb_q;
  logic [57:0] s1, s2sum;
  logic [31:0] k1_q, k2_q;
  logic [63:0] sq1_q, sq2_q;
  logic [28:0] c2_5_q, c2_6_q, c2_7_q, c2_8_q, c2_9_q;
  logic [27:0] cs_5_q, cs_6_q, cs_7_q, cs_8_q, cs_9_q;
  logic        ng_5_q, ng_6_q, ng_7_q, ng_8_q, ng_9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v5_q <= vdw;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  assign s1    = {1'b0, m1_q} + {1'b0, mb_q};
  assign s2sum = {1'b0, m2_q} + {1'b0, mb_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dw5_q  <= dw_cl;
      p1_5_q <= ks_q * pdw.r.aniso;
      p2_5_q <= kq_q * pdw.r.aniso;
      c2_5_q <= pdw.r.c2;
      cs_5_q <= pdw.r.csm;
      ng_5_q <= pdw.r.neg;

      k1h6_q <= (p1_5_q[63:56] != '0) ? '1 : p1_5_q[55:24];
      k2h6_q <= (p2_5_q[63:56] != '0) ? '1 : p2_5_q[55:24];
      wdw6_q <= ONE24 - dw5_q;
      dw6_q  <= dw5_q;
      c2_6_q <= c2_5_q;
      cs_6_q <= cs_5_q;
      ng_6_q <= ng_5_q;

      m1_q   <= wdw6_q * k1h6_q;
      m2_q   <= wdw6_q * k2h6_q;
      mb_q   <= dw6_q * base_q;
      c2_7_q <= c2_6_q;
      cs_7_q <= cs_6_q;
      ng_7_q <= ng_6_q;

      k1_q   <= s1[55:24];
      k2_q   <= s2sum[55:24];
      c2_8_q <= c2_7_q;
      cs_8_q <= cs_7_q;
      ng_8_q <= ng_7_q;

      sq1_q  <= k1_q * k1_q;
      sq2_q  <= k2_q * k2_q;
      c2_9_q <= c2_8_q;
      cs_9_q <= cs_8_q;
      ng_9_q <= ng_8_q;
    end
  end

  logic [47:0] kr1, kr2;
  r1_side_t    r1_in;
  logic        vr1;
  logic [56:0] r1q;
  r1_side_t    pr1;

  assign kr1       = (sq1_q[63:16] == '0) ? 48'd1 : sq1_q[63:16];
  assign kr2       = (sq2_q[63:16] == '0) ? 48'd1 : sq2_q[63:16];
  assign r1_in.kr2 = kr2;
  assign r1_in.c2  = c2_9_q;
  assign r1_in.csm = cs_9_q;
  assign r1_in.neg = ng_9_q;

  akt_div #(.NW(58), .DW(48), .QW(57), .SW($bits(r1_side_t))) u_div_r1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v9_q),
    .num_i(R_NUM), .den_i(kr1), .side_i(r1_in),
    .vld_o(vr1), .quo_o(r1q), .side_o(pr1)
  );

  r2_side_t    r2_in;
  logic        vr2;
  logic [56:0] r2q;
  r2_side_t    pr2;

  assign r2_in.r1  = r1q;
  assign r2_in.c2  = pr1.c2;
  assign r2_in.csm = pr1.csm;
  assign r2_in.neg = pr1.neg;

  akt_div #(.NW(58), .DW(48), .QW(57), .SW($bits(r2_side_t))) u_div_r2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vr1),
    .num_i(R_NUM), .den_i(pr1.kr2), .side_i(r2_in),
    .vld_o(vr2), .quo_o(r2q), .side_o(pr2)
  );

  logic        v11_q, v12_q, v13_q;
  logic [56:0] r1_11_q, r2_11_q, dm_11_q;
  logic        dneg_11_q, dneg_12_q, ng_11_q, ng_12_q;
  logic [28:0] c2_11_q, s2_11_q;
  logic [27:0] cs_11_q;
  logic [28:0] fa [5];
  logic [56:0] fb [5];
  logic [57:0] hi_q [5];
  logic [56:0] lo_q [5];
  logic [58:0] tsum [5];
  logic [50:0] term [5];
  logic [51:0] xx13_q, yy13_q;
  logic [50:0] xym13_q;
  logic        xyneg13_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else if (en) begin
      v11_q <= vr2;
      v12_q <= v11_q;
      v13_q <= v12_q;
    end
  end

  // term order: c2*r2, s2*r1, s2*r2, c2*r1, cs*|r1-r2|
  assign fa[0] = c2_11_q;
  assign fb[0] = r2_11_q;
  assign fa[1] = s2_11_q;
  assign fb[1] = r1_11_q;
  assign fa[2] = s2_11_q;
  assign fb[2] = r2_11_q;
  assign fa[3] = c2_11_q;
  assign fb[3] = r1_11_q;
  assign fa[4] = {1'b0, cs_11_q};
  assign fb[4] = dm_11_q;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      tsum[i] = {1'b0, hi_q[i]} + {30'd0, lo_q[i][56:28]};
      term[i] = tsum[i][58:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_11_q   <= pr2.r1;
      r2_11_q   <= r2q;
      dneg_11_q <= pr2.r1 > r2q;
      dm_11_q   <= (pr2.r1 > r2q) ? (pr2.r1 - r2q) : (r2q - pr2.r1);
      c2_11_q   <= pr2.c2;
      s2_11_q   <= ONE28 - pr2.c2;
      cs_11_q   <= pr2.csm;
      ng_11_q   <= pr2.neg;

      for (int i = 0; i < 5; i++) begin
        hi_q[i] <= fa[i] * fb[i][56:28];
        lo_q[i] <= fa[i] * fb[i][27:0];
      end
      dneg_12_q <= dneg_11_q;
      ng_12_q   <= ng_11_q;

      xx13_q    <= {1'b0, term[0]} + {1'b0, term[1]};
      yy13_q    <= {1'b0, term[2]} + {1'b0, term[3]};
      xym13_q   <= term[4];
      xyneg13_q <= (ng_12_q != dneg_12_q) && (term[4] != '0);
    end
  end

  logic        sat_xx, sat_yy, sat_xy;
  logic [47:0] o_xx, o_yy, o_xy, xy_mag;

  always_comb begin
    sat_xx = xx13_q > 52'(OUT_MAX);
    sat_yy = yy13_q > 52'(OUT_MAX);
    o_xx   = sat_xx ? OUT_MAX : xx13_q[47:0];
    o_yy   = sat_yy ? OUT_MAX : yy13_q[47:0];
    if (xyneg13_q) begin
      sat_xy = xym13_q > 51'(OUT_MIN);
      xy_mag = sat_xy ? OUT_MIN : xym13_q[47:0];
      o_xy   = ~xy_mag + 48'd1;
    end else begin
      sat_xy = xym13_q > 51'(OUT_MAX);
      xy_mag = sat_xy ? OUT_MAX : xym13_q[47:0];
      o_xy   = xy_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inverse_xx_o <= o_xx;
      inverse_yy_o <= o_yy;
      inverse_xy_o <= o_xy;
      saturated_o  <= sat_xx | sat_yy | sat_xy;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/akt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module akt_div #(
  parameter int unsigned NW = 62,
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 29,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // expects num_i < den_i * 2^QW
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] nq_q   [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] nq_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = DW'(num_i[NW-1:QW]);
      assign nq_in   = num_i[QW-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {rem_in, nq_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (trial[DW-1:0] - den_in) : trial[DW-1:0];
        nq_q[k]   <= {nq_in[QW-2:0], take};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = nq_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

// ===== rtl/akt_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none

module akt_sqrt #(
  parameter int unsigned IW = 64,
  parameter int unsigned SW = 8,
  localparam int unsigned RW = IW / 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [IW-1:0] rad_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [RW-1:0] root_o,
  output logic [SW-1:0] side_o
);

  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [IW-1:0] rad_q  [RW];
  logic [SW-1:0] side_q [RW];
  logic          vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [IW-1:0] rad_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [RW+2:0] trial;
    logic [RW+2:0] tst;
    logic [RW+2:0] diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {rem_in, rad_in[IW-1:IW-2]};
    assign tst   = {1'b0, root_in, 2'b01};
    assign take  = trial >= tst;
    assign diff  = trial - tst;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[RW:0] : trial[RW:0];
        root_q[k] <= {root_in[RW-2:0], take};
        rad_q[k]  <= {rad_in[IW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

`default_nettype wire

// ===== verif/tb_anisotropic_kernel_from_tensor_top.sv =====
// Self-checking testbench for the anisotropic kernel covariance block.
`timescale 1ns / 100ps

module tb_anisotropic_kernel_from_tensor_top;
  import akt_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] inv_xx;
    logic [OUT_W-1:0] inv_yy;
    logic [OUT_W-1:0] inv_xy;
    logic             sat;
  } kernel_t;

  localparam longint unsigned U24 = 64'd1 << 24;
  localparam longint unsigned U28 = 64'd1 << 28;
  localparam longint unsigned U32M = 64'hFFFF_FFFF;
  localparam longint unsigned OMAX = (64'd1 << 47) - 1;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;
  localparam int LATENCY = 320;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TEN_W-1:0] t_xx = '0, t_yy = '0, t_xy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] o_xx, o_yy, o_xy;
  logic o_sat;

  logic [REG_W-1:0] regs [6];
  kernel_t kernel_q [$];
  int mismatches = 0;
  bit no_gaps = 0;
  bit hold_go = 0;
  logic hold_on = 1'b0;
  int rx_wait = 0;

  anisotropic_kernel_from_tensor_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .tensor_xx_i(t_xx), .tensor_yy_i(t_yy), .tensor_xy_i(t_xy),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .inverse_xx_o(o_xx), .inverse_yy_o(o_yy), .inverse_xy_o(o_xy),
    .saturated_o(o_sat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sat_u32(longint unsigned v);
    return (v > U32M) ? U32M : v;
  endfunction

  function automatic longint unsigned mul_shr36(longint unsigned a, longint unsigned b);
    return (a * (b >> 28) + ((a * (b & (U28 - 1))) >> 28)) >> 8;
  endfunction

  function automatic longint unsigned recip_sq(longint unsigned k);
    longint unsigned kr;
    kr = (k * k) >> 16;
    if (kr == 0) kr = 1;
    return (64'd1 << 56) / kr;
  endfunction

  function automatic longint unsigned blend(longint unsigned kh, longint unsigned base,
                                            longint unsigned dw);
    return ((U24 - dw) * kh + dw * base) >> 24;
  endfunction

  function automatic kernel_t predict_kernel(logic [31:0] txx, logic [31:0] tyy,
                                             logic [31:0] txy);
    longint unsigned a11, a22, ad, ax, hh, c2, s2, csm, t, lam1, aniso, root;
    longint unsigned dtr, shr, ks, k1h, kq, k2h, base, k1, k2, r1, r2, sxx, syy, dm, xym;
    longint a12, d, num, dw;
    bit csneg, dneg, xyneg;
    kernel_t res;
    a11 = txx;
    a22 = tyy;
    a12 = longint'($signed(txy));
    d = longint'(a22) - longint'(a11);
    ad = (d < 0) ? longint'(-d) : d;
    ax = (a12 < 0) ? longint'(-a12) : a12;
    hh = int_sqrt(((ad * ad) >> 2) + ax * ax);
    csneg = a12 < 0;
    csm = 0;
    if (hh == 0) begin
      c2 = U28;
    end else begin
      num = 2 * longint'(hh) - d;
      if (num < 0) num = 0;
      if (num > 4 * longint'(hh)) num = 4 * longint'(hh);
      c2 = (longint'(num) << 28) / (4 * hh);
      csm = (ax << 28) / (2 * hh);
      if (csm > (U28 >> 1)) csm = U28 >> 1;
    end
    s2 = U28 - c2;
    t = a11 + a22;
    lam1 = (t + 2 * hh) >> 1;
    aniso = (t == 0) ? U24 : sat_u32(U24 + ((2 * hh) << 24) / t);
    root = int_sqrt(lam1 << 20);
    dtr = (regs[REG_TRANSITION] != 0) ? regs[REG_TRANSITION] : 1;
    dw = longint'(U24) + longint'({32'd0, regs[REG_THRESHOLD]}) - longint'((root << 24) / dtr);
    if (dw < 0) dw = 0;
    if (dw > longint'(U24)) dw = U24;
    shr = (regs[REG_SHRINK] != 0) ? regs[REG_SHRINK] : 1;
    ks = sat_u32((longint'(regs[REG_DETAIL]) * regs[REG_STRETCH]) >> 24);
    k1h = sat_u32((ks * aniso) >> 24);
    kq = sat_u32((longint'(regs[REG_DETAIL]) << 24) / shr);
    k2h = sat_u32((kq * aniso) >> 24);
    base = sat_u32((longint'(regs[REG_DETAIL]) * regs[REG_DENOISE]) >> 24);
    k1 = blend(k1h, base, dw);
    k2 = blend(k2h, base, dw);
    r1 = recip_sq(k1);
    r2 = recip_sq(k2);
    sxx = mul_shr36(c2, r2) + mul_shr36(s2, r1);
    syy = mul_shr36(s2, r2) + mul_shr36(c2, r1);
    dneg = r1 > r2;
    dm = dneg ? r1 - r2 : r2 - r1;
    xym = mul_shr36(csm, dm);
    xyneg = (csneg != dneg) && (xym != 0);
    res.sat = 1'b0;
    if (sxx > OMAX) begin sxx = OMAX; res.sat = 1'b1; end
    if (syy > OMAX) begin syy = OMAX; res.sat = 1'b1; end
    if (xyneg) begin
      if (xym > OMAX + 1) begin xym = OMAX + 1; res.sat = 1'b1; end
      xym = -xym;
    end else if (xym > OMAX) begin
      xym = OMAX;
      res.sat = 1'b1;
    end
    res.inv_xx = sxx[OUT_W-1:0];
    res.inv_yy = syy[OUT_W-1:0];
    res.inv_xy = xym[OUT_W-1:0];
    return res;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    kernel_t got, want;
    if (out_valid && out_ready) begin
      got = '{o_xx, o_yy, o_xy, o_sat};
      if (kernel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", got);
      end else begin
        want = kernel_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp xx=%h yy=%h xy=%h sat=%b got xx=%h yy=%h xy=%h sat=%b",
                     want.inv_xx, want.inv_yy, want.inv_xy, want.sat,
                     got.inv_xx, got.inv_yy, got.inv_xy, got.sat);
        end
      end
      rx_wait = no_gaps ? 0 : $urandom_range(0, 6);
    end
    if (hold_on) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // long receiver hold-off
  always begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (700) @(posedge clk);
    hold_on <= 1'b0;
    hold_go = 0;
  end

  task automatic send_item(logic [31:0] xx, logic [31:0] yy, logic [31:0] xy);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    t_xx <= xx;
    t_yy <= yy;
    t_xy <= xy;
    do @(posedge clk); while (!in_ready);
    kernel_q.push_back(predict_kernel(xx, yy, xy));
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (kernel_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_SHRINK) regs[idx] = val;
  endtask

  task automatic set_all(logic [REG_W-1:0] thr, logic [REG_W-1:0] trn,
                         logic [REG_W-1:0] det, logic [REG_W-1:0] den,
                         logic [REG_W-1:0] str, logic [REG_W-1:0] shk);
    drain();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_TRANSITION, trn);
    write_reg(REG_DETAIL, det);
    write_reg(REG_DENOISE, den);
    write_reg(REG_STRETCH, str);
    write_reg(REG_SHRINK, shk);
    cfg_we <= 1'b0;
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_tensor();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(4, 31);
      2: return $urandom_range(0, 3);
      default: return $urandom() >> 12;
    endcase
  endfunction

  task automatic test_directed();
    send_item('0, '0, '0);
    send_item('1, '1, 32'h7FFF_FFFF);
    send_item('1, '1, 32'h8000_0000);
    send_item('1, '0, '0);
    send_item('0, '1, '0);
    send_item(32'h1000_0000, 32'h1000_0000, '0);
    send_item('0, '0, 32'h8000_0000);
    send_item('0, '0, 32'h0000_0001);
    send_item('0, '0, '1);
    send_item(32'h0100_0000, 32'h0010_0000, 32'hFF00_0000);
    send_item(32'h0000_0100, 32'h0000_0100, 32'h0000_0100);
    send_item(32'h0000_0001, '0, '0);
    send_item('1, '0, 32'h8000_0000);
    stop_input();
  endtask

  task automatic test_register_extremes();
    set_all('0, '0, '0, '0, '0, '0);
    test_directed();
    set_all('1, '1, '1, '1, '1, '1);
    test_directed();
    set_all('0, 32'd1, '1, '0, '1, 32'd1);
    test_directed();
    drain();
    write_reg(IDX_SPARE_A, '1);
    write_reg(IDX_SPARE_B, '0);
    set_all(RST_THRESHOLD, RST_TRANSITION, RST_DETAIL, RST_DENOISE, RST_STRETCH,
            RST_SHRINK);
    test_directed();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0)
        set_all($urandom(), $urandom() >> $urandom_range(0, 24), $urandom() >> $urandom_range(0, 8),
                $urandom() >> $urandom_range(0, 8), $urandom() >> $urandom_range(0, 8),
                $urandom() >> $urandom_range(0, 8));
      no_gaps = (ph == 2);
      for (int i = 0; i < 45; i++) send_item(rand_tensor(), rand_tensor(), rand_tensor());
      stop_input();
    end
    no_gaps = 0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_go = 1;
    no_gaps = 1;
    for (int i = 0; i < 150; i++) send_item(rand_tensor(), rand_tensor(), rand_tensor());
    stop_input();
    no_gaps = 0;
  endtask

  initial begin
    for (int r = 0; r < 6; r++) regs[r] = '0;
    regs[REG_THRESHOLD] = RST_THRESHOLD;
    regs[REG_TRANSITION] = RST_TRANSITION;
    regs[REG_DETAIL] = RST_DETAIL;
    regs[REG_DENOISE] = RST_DENOISE;
    regs[REG_STRETCH] = RST_STRETCH;
    regs[REG_SHRINK] = RST_SHRINK;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random();
    test_backpressure();
    drain();
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && kernel_q.size() == 0)
      $display("tb_anisotropic_kernel_from_tensor_top: clean");
    else
      $display("tb_anisotropic_kernel_from_tensor_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_anisotropic_kernel_from_tensor_top: errors");
    $finish;
  end

endmodule

// ===== anisotropic_kernel_from_tensor_top.f =====
rtl/akt_pkg.sv
rtl/akt_div.sv
rtl/akt_sqrt.sv
rtl/anisotropic_kernel_from_tensor_top.sv
verif/tb_anisotropic_kernel_from_tensor_top.sv
